[rtl/sua_pkg.sv]
// ----------------------------------------------------------------------------
// sua_pkg
// Shared types, constants and lead byte decoding for the serial UTF-8
// character assembler.
// ----------------------------------------------------------------------------
package sua_pkg;

  localparam int unsigned CHAR_W            = 48;
  localparam int unsigned NBYTES_W          = 3;
  localparam int unsigned MSG_LEN_W         = 32;
  localparam int unsigned MAX_SEQ_BYTES_DEF = 6;
  localparam int unsigned COUNT_WIDTH_DEF   = 32;

  localparam logic [7:0] LEAD_MASK_6 = 8'd252;
  localparam logic [7:0] LEAD_MASK_5 = 8'd248;
  localparam logic [7:0] LEAD_MASK_4 = 8'd240;
  localparam logic [7:0] LEAD_MASK_3 = 8'd224;
  localparam logic [7:0] LEAD_MASK_2 = 8'd192;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_bytes;
    logic [NBYTES_W-1:0] byte_count;
    logic                message_done;
  } sua_result_t;

  function automatic logic [NBYTES_W-1:0] lead_bytes(input logic [7:0]          lead,
                                                      input logic [NBYTES_W-1:0] max_bytes);
    logic [NBYTES_W-1:0] n;
    if ((lead & LEAD_MASK_6) == LEAD_MASK_6) begin
      n = 3'd6;
    end else if ((lead & LEAD_MASK_5) == LEAD_MASK_5) begin
      n = 3'd5;
    end else if ((lead & LEAD_MASK_4) == LEAD_MASK_4) begin
      n = 3'd4;
    end else if ((lead & LEAD_MASK_3) == LEAD_MASK_3) begin
      n = 3'd3;
    end else if ((lead & LEAD_MASK_2) == LEAD_MASK_2) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    if (n > max_bytes) begin
      n = max_bytes;
    end
    return n;
  endfunction

endpackage

[rtl/sua_in_reg.sv]
// ----------------------------------------------------------------------------
// sua_in_reg
// Input register: captures one received bit per transfer and holds it until
// the assembler core takes it.
// ----------------------------------------------------------------------------
module sua_in_reg
  import sua_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic bit_i,
  input  logic take_i,
  output logic valid_o,
  output logic bit_o
);

  logic valid_q, valid_d;
  logic bit_q, bit_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    bit_d   = bit_q;
    if (ready_o) begin
      valid_d = valid_i;
      bit_d   = bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign valid_o = valid_q;
  assign bit_o   = bit_q;

endmodule

[rtl/sua_core.sv]
// ----------------------------------------------------------------------------
// sua_core
// Assembler core: shifts bits into the character buffer, decodes the lead
// byte, counts message bytes and produces one result per character.
// ----------------------------------------------------------------------------
module sua_core
  import sua_pkg::*;
#(
  parameter int unsigned MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF,
  parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 bit_i,
  input  logic                 cfg_we_i,
  input  logic [MSG_LEN_W-1:0] cfg_data_i,
  output logic                 push_o,
  output sua_result_t          result_o
);

  localparam int unsigned BW    = MAX_SEQ_BYTES * 8;
  localparam int unsigned BC_W  = $clog2(BW + 1);
  localparam int unsigned IDX_W = $clog2(BW);
  localparam int unsigned CMP_W = (COUNT_WIDTH > MSG_LEN_W) ? COUNT_WIDTH : MSG_LEN_W;

  logic [BW-1:0]          buf_q, buf_d, buf_n;
  logic [BC_W-1:0]        bc_q, bc_d, bc_n, idx;
  logic [BC_W-1:0]        exp_q, exp_d, exp_n;
  logic [COUNT_WIDTH-1:0] total_q, total_d, total_sat;
  logic [COUNT_WIDTH:0]   total_sum;
  logic [MSG_LEN_W-1:0]   msg_len_q;
  logic [NBYTES_W-1:0]    nbytes;
  logic                   emit, done;

  always_comb begin
    buf_n = buf_q;
    bc_n  = bc_q;
    idx   = BC_W'(BW - 1) - bc_q;
    if (bc_q < BC_W'(BW)) begin
      buf_n[idx[IDX_W-1:0]] = bit_i;
      bc_n = bc_q + 1'b1;
    end

    exp_n = exp_q;
    emit  = 1'b0;
    if (bc_n == exp_q) begin
      if (exp_q == BC_W'(8)) begin
        exp_n = BC_W'({lead_bytes(buf_n[BW-1 -: 8], NBYTES_W'(MAX_SEQ_BYTES)), 3'b000});
      end
      emit = (bc_n == exp_n);
    end

    nbytes    = NBYTES_W'(bc_n >> 3);
    total_sum = {1'b0, total_q} + (COUNT_WIDTH + 1)'(nbytes);
    total_sat = total_sum[COUNT_WIDTH] ? '1 : total_sum[COUNT_WIDTH-1:0];
    done      = CMP_W'(total_sat) >= CMP_W'(msg_len_q);

    buf_d   = buf_q;
    bc_d    = bc_q;
    exp_d   = exp_q;
    total_d = total_q;
    if (step_i) begin
      if (emit) begin
        buf_d   = '0;
        bc_d    = '0;
        exp_d   = BC_W'(8);
        total_d = done ? '0 : total_sat;
      end else begin
        buf_d = buf_n;
        bc_d  = bc_n;
        exp_d = exp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= '0;
      bc_q      <= '0;
      exp_q     <= BC_W'(8);
      total_q   <= '0;
      msg_len_q <= '0;
    end else begin
      buf_q   <= buf_d;
      bc_q    <= bc_d;
      exp_q   <= exp_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        msg_len_q <= cfg_data_i;
      end
    end
  end

  assign push_o                = step_i && emit;
  assign result_o.char_bytes   = CHAR_W'(buf_n) << (CHAR_W - BW);
  assign result_o.byte_count   = nbytes;
  assign result_o.message_done = done;

endmodule

[rtl/sua_out_buf.sv]
// ----------------------------------------------------------------------------
// sua_out_buf
// Result register with a skid stage: holds finished characters until the
// downstream side takes them.
// ----------------------------------------------------------------------------
module sua_out_buf
  import sua_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sua_result_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        ready_i,
  output sua_result_t data_o
);

  sua_result_t out_q, out_d, skid_q, skid_d;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic        pop;

  assign ready_o = !skid_valid_q;
  assign pop     = out_valid_q && ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

[rtl/serial_utf8_char_assembler_unit.sv]
// ----------------------------------------------------------------------------
// serial_utf8_char_assembler_unit
// Bit-serial UTF-8 character assembler: shifts bits into characters, emits
// each completed character with its byte count and flags message completion.
//
//   channel   dir  width  payload
//   s_axis    in   8      tdata[0] bit_value
//   m_axis    out  56+1   tdata char_bytes, byte_count; tuser message_done
//   cfg       in   32     message_length
//
// One bit per cycle sustained while the skid stage is not full. A result
// goes through the input register, then the result register, on its way out.
// Reset clears the buffer, counters and message length; no clearing pass.
// A two-entry result buffer decouples stalls; s_axis_tready drops only when
// the skid stage is full and the input register is occupied.
// ----------------------------------------------------------------------------
module serial_utf8_char_assembler_unit
  import sua_pkg::*;
#(
  parameter int unsigned MAX_SEQ_BYTES = MAX_SEQ_BYTES_DEF,
  parameter int unsigned COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [0] bit_value
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,   // [47:0] char_bytes, [50:48] byte_count
  output logic [0:0]           m_axis_tuser,   // [0] message_done
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [MSG_LEN_W-1:0] cfg_data_i
);

  logic        in_valid, in_bit, out_ready, step, push;
  sua_result_t core_res, out_res;

  assign step        = in_valid && out_ready;
  assign cfg_ready_o = 1'b1;

  sua_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .bit_i   (s_axis_tdata[0]),
    .take_i  (out_ready),
    .valid_o (in_valid),
    .bit_o   (in_bit)
  );

  sua_core #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .bit_i      (in_bit),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .result_o   (core_res)
  );

  sua_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (core_res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.byte_count, out_res.char_bytes};
  assign m_axis_tuser = out_res.message_done;

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_ready)
    else $error("result pushed into full output buffer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[50:48] != 3'd0) &&
                      (m_axis_tdata[50:48] <= NBYTES_W'(MAX_SEQ_BYTES)))
    else $error("byte count out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid && !out_ready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

[tb/sv/tb_serial_utf8_char_assembler_unit.sv]
// ----------------------------------------------------------------------------
// tb_serial_utf8_char_assembler_unit
// Self-checking testbench for the bit-serial UTF-8 character assembler.
// Feeds bits MSB first as whole characters of every length, plus stray bits
// and cut-off characters, under random stalls on both stream sides. An
// in-bench character assembler predicts every emitted character, byte count
// and message-done flag; a monitor compares each result transfer in order.
// The message length is rewritten between phases and during random traffic, after pending results drain.
// ----------------------------------------------------------------------------
module tb_serial_utf8_char_assembler_unit;
  import sua_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEQ_MAX = MAX_SEQ_BYTES_DEF;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [MSG_LEN_W-1:0] cfg_data_i    = '0;

  serial_utf8_char_assembler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // assembler model state
  logic [CHAR_W-1:0]    char_acc;
  int unsigned          acc_bits;
  int unsigned          need_bits;
  logic [31:0]          msg_total;
  logic [MSG_LEN_W-1:0] msg_len;

  sua_result_t pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_bits      = 0;
  bit          idle_en        = 1'b1;
  int unsigned stall_left     = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned char_len(input logic [7:0] lead);
    int unsigned n;
    casez (lead)
      8'b111111??: n = 6;
      8'b11111???: n = 5;
      8'b1111????: n = 4;
      8'b111?????: n = 3;
      8'b11??????: n = 2;
      default:     n = 1;
    endcase
    return (n > SEQ_MAX) ? SEQ_MAX : n;
  endfunction

  task automatic assemble_bit(input logic b);
    int unsigned nbytes;
    logic [32:0] sum;
    sua_result_t r;
    if (acc_bits < CHAR_W) begin
      char_acc[CHAR_W-1-acc_bits] = b;
      acc_bits++;
    end
    if (acc_bits != need_bits) return;
    if (need_bits == 8) need_bits = char_len(char_acc[47:40]) * 8;
    if (acc_bits != need_bits) return;
    nbytes = acc_bits / 8;
    sum = {1'b0, msg_total} + 33'(nbytes);
    if (sum[32]) sum = {1'b0, 32'hFFFF_FFFF};
    msg_total = sum[31:0];
    r.char_bytes   = char_acc;
    r.byte_count   = NBYTES_W'(nbytes);
    r.message_done = (msg_total >= msg_len);
    pending_chars.push_back(r);
    char_acc  = '0;
    acc_bits  = 0;
    need_bits = 8;
    if (r.message_done) msg_total = '0;
  endtask

  // result monitor
  initial begin
    sua_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected result transfer: tdata %0h tuser %0h", m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          exp_r = pending_chars.pop_front();
          if (m_axis_tdata[47:0] !== exp_r.char_bytes) begin
            $error("char_bytes: expected %0h actual %0h", exp_r.char_bytes, m_axis_tdata[47:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[50:48] !== exp_r.byte_count) begin
            $error("byte_count: expected %0d actual %0d", exp_r.byte_count, m_axis_tdata[50:48]);
            mismatch_count++;
          end
          if (m_axis_tuser[0] !== exp_r.message_done) begin
            $error("message_done: expected %0b actual %0b", exp_r.message_done, m_axis_tuser[0]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // result backpressure
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && ($urandom % 6 == 0)) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_bit(input logic b);
    if (idle_en && ($urandom % 5 == 0)) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, b};
    do @(posedge clk_i); while (!s_axis_tready);
    assemble_bit(b);
    sent_bits++;
  endtask

  task automatic send_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) send_bit(v[i]);
  endtask

  task automatic send_char(input logic [7:0] lead, input logic [7:0] fill);
    send_byte(lead);
    for (int i = 1; i < char_len(lead); i++) send_byte(fill);
  endtask

  task automatic send_random_char();
    int unsigned n;
    logic [7:0] lead;
    n    = $urandom_range(1, SEQ_MAX);
    lead = 8'($urandom);
    if (n == 1) lead = ($urandom % 2) ? {1'b0, lead[6:0]} : {2'b10, lead[5:0]};
    else if (n == 6) lead = 8'hFC | lead;
    else lead = (8'hFF << (8 - n)) | (lead & (8'hFF >> (n + 1)));
    send_byte(lead);
    for (int i = 1; i < n; i++) send_byte(8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_msg_len(input logic [MSG_LEN_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    msg_len = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_zero_length_chars();
    logic [7:0] leads[11] = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hDF,
                              8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFF};
    for (int i = 0; i < 11; i++) send_char(leads[i], (i % 2) ? 8'hFF : 8'h00);
  endtask

  task automatic test_message_length();
    write_msg_len(32'd5);
    repeat (4) send_random_char();
    write_msg_len(32'd1);
    repeat (2) send_random_char();
  endtask

  task automatic test_length_extremes();
    write_msg_len(32'hFFFF_FFFF);
    repeat (2) send_random_char();
    write_msg_len(32'd0);
    repeat (2) send_random_char();
    write_msg_len(32'($urandom));
    repeat (2) send_random_char();
  endtask

  task automatic test_random_traffic();
    int unsigned start_bits;
    int unsigned next_cfg;
    start_bits = sent_bits;
    next_cfg   = sent_bits + 80;
    while (sent_bits - start_bits < 120) begin
      if (sent_bits - start_bits > 80) idle_en = 1'b0;
      if (sent_bits >= next_cfg) begin
        write_msg_len(($urandom % 8 == 0) ? 32'($urandom) : 32'($urandom_range(1, 40)));
        next_cfg = sent_bits + 80;
      end
      if ($urandom % 10 == 0) begin
        repeat ($urandom_range(1, 12)) send_bit(1'($urandom));
      end else begin
        send_random_char();
      end
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    char_acc  = '0;
    acc_bits  = 0;
    need_bits = 8;
    msg_total = '0;
    msg_len   = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_zero_length_chars();
    test_message_length();
    test_length_extremes();
    test_random_traffic();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_chars.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("%0d expected results never arrived", pending_chars.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sua_pkg.sv
rtl/sua_in_reg.sv
rtl/sua_core.sv
rtl/sua_out_buf.sv
rtl/serial_utf8_char_assembler_unit.sv
tb/sv/tb_serial_utf8_char_assembler_unit.sv
